FILE: design/cau_pkg.sv
// Shared types, codes and helpers for the complex arithmetic unit.
package cau_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_EXP_DEF   = 15;
  localparam logic [15:0] TOL_RESET = 16'd66;
  localparam int ACC_W = 66;

  // Register byte addresses
  localparam logic [1:0] ADDR_TOL = 2'd0;

  typedef enum logic [3:0] {
    CMD_ADD  = 4'd0,
    CMD_SUB  = 4'd1,
    CMD_MUL  = 4'd2,
    CMD_DIV  = 4'd3,
    CMD_CONJ = 4'd4,
    CMD_MOD  = 4'd5,
    CMD_MSQ  = 4'd6,
    CMD_POW  = 4'd7,
    CMD_EQ   = 4'd8
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_MUL,
    S_ACC,
    S_POST,
    S_DIV,
    S_SQRT,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    OP_AR,
    OP_AI,
    OP_YR,
    OP_YI
  } opnd_t;

  typedef struct packed {
    logic [3:0]         cmd;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
    logic [3:0]         exponent;
  } req_t;

  typedef struct packed {
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic [31:0]        magnitude;
    logic               is_equal;
    logic               div_zero;
    logic               overflow;
  } res_t;

  typedef struct packed {
    logic        ov;
    logic [31:0] val;
  } sat_t;

  // Clamp a wide signed value into 32-bit signed range
  function automatic sat_t sat32(input logic signed [ACC_W-1:0] v);
    sat_t r;
    if (v > ACC_W'(64'sh7FFFFFFF)) begin
      r.ov  = 1'b1;
      r.val = 32'h7FFFFFFF;
    end else if (v < -ACC_W'(64'sh80000000)) begin
      r.ov  = 1'b1;
      r.val = 32'h80000000;
    end else begin
      r.ov  = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

  // Apply sign and saturation to a quotient magnitude
  function automatic sat_t div_sat(input logic neg, input logic big, input logic [32:0] q);
    sat_t r;
    r.ov = 1'b0;
    if (!neg) begin
      if (big || q > 33'h07FFFFFFF) begin
        r.ov  = 1'b1;
        r.val = 32'h7FFFFFFF;
      end else begin
        r.val = q[31:0];
      end
    end else begin
      if (big || q > 33'h080000000) begin
        r.ov  = 1'b1;
        r.val = 32'h80000000;
      end else begin
        r.val = 32'(33'd0 - q);
      end
    end
    return r;
  endfunction

endpackage

FILE: design/complex_arith_unit_core.sv
// Complex arithmetic unit: sequencer around one shared 32x32 multiplier.
// Add, sub, conj, equal and unknown codes finish from the start state; mul, mag squared,
//   mod, power and divide use the multiplier; mod then runs a square root, divide a serial
//   divider that is skipped when the divisor is zero; power at exponent 0 skips the multiplier.
// One request at a time: req_ready is high only while the sequencer is idle, so
//   a new request waits until the last result has been taken (result handshake, idle).
// Reset (rst, synchronous, active high) returns the sequencer to idle, drops
//   res_valid and sets the tolerance register tol to 66.
module complex_arith_unit_core
  import cau_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MAX_EXP   = MAX_EXP_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  output logic        res_valid,
  input  logic        res_ready,
  output res_t        res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NW = 64 + FRAC_BITS;
  localparam int DCW = $clog2(NW);
  localparam int PW = ($clog2(MAX_EXP + 1) > 4) ? $clog2(MAX_EXP + 1) : 4;
  localparam logic signed [31:0] ONE = 32'sd1 << FRAC_BITS;

  state_t state, state_next;

  logic [15:0] tol;
  cmd_t        cmd;
  logic signed [31:0] ar, ai, br, bi, yr, yi;
  logic [PW-1:0] pcnt;
  logic [2:0]    term;
  logic signed [63:0] prod;
  logic signed [ACC_W-1:0] acc, pr0, pr1, pr2;
  logic ov;
  res_t out;

  // divider state
  logic [NW-1:0] numsh;
  logic [63:0]   drem;
  logic [32:0]   dq;
  logic          dbig, dneg, dsel;
  logic [DCW-1:0] dcnt;

  // square root state
  logic [63:0] vsh;
  logic [35:0] srem;
  logic [31:0] sroot;
  logic [4:0]  scnt;

  // Operand select and sign for the current product term
  opnd_t sel_a, sel_b;
  logic  tneg;
  logic [2:0] last_term;
  logic signed [31:0] opa, opb;

  always_comb begin
    sel_a = OP_AR;
    sel_b = OP_YR;
    tneg  = 1'b0;
    last_term = 3'd3;
    case (cmd)
      CMD_DIV: begin
        last_term = 3'd5;
        case (term)
          3'd0: begin sel_a = OP_YR; sel_b = OP_YR; end
          3'd1: begin sel_a = OP_YI; sel_b = OP_YI; end
          3'd2: begin sel_a = OP_AR; sel_b = OP_YR; end
          3'd3: begin sel_a = OP_AI; sel_b = OP_YI; end
          3'd4: begin sel_a = OP_AI; sel_b = OP_YR; end
          default: begin sel_a = OP_AR; sel_b = OP_YI; tneg = 1'b1; end
        endcase
      end
      CMD_MOD, CMD_MSQ: begin
        last_term = 3'd1;
        if (term[0]) begin
          sel_a = OP_AI; sel_b = OP_AI;
        end else begin
          sel_a = OP_AR; sel_b = OP_AR;
        end
      end
      default: begin
        case (term)
          3'd0: begin sel_a = OP_AR; sel_b = OP_YR; end
          3'd1: begin sel_a = OP_AI; sel_b = OP_YI; tneg = 1'b1; end
          3'd2: begin sel_a = OP_AR; sel_b = OP_YI; end
          default: begin sel_a = OP_AI; sel_b = OP_YR; end
        endcase
      end
    endcase
  end

  always_comb begin
    case (sel_a)
      OP_AR:   opa = ar;
      OP_AI:   opa = ai;
      OP_YR:   opa = yr;
      default: opa = yi;
    endcase
    case (sel_b)
      OP_AR:   opb = ar;
      OP_AI:   opb = ai;
      OP_YR:   opb = yr;
      default: opb = yi;
    endcase
  end

  // Signed product term, extended and negated as asked
  logic signed [ACC_W-1:0] tval, pair_sum;
  always_comb begin
    tval = {{(ACC_W-64){prod[63]}}, prod};
    if (tneg) tval = -tval;
    pair_sum = acc + tval;
  end

  // Complex product results after floor shift
  sat_t m_re, m_im;
  always_comb begin
    m_re = sat32(pr0 >>> FRAC_BITS);
    m_im = sat32(pr1 >>> FRAC_BITS);
  end

  // Restoring divide step
  logic [64:0] d_r2;
  logic        d_qb;
  logic [63:0] d_rem_n;
  logic [32:0] d_q_n;
  logic        d_big_n;
  sat_t        d_res;
  always_comb begin
    d_r2 = {drem, numsh[NW-1]};
    d_qb = (d_r2 >= {1'b0, pr0[63:0]});
    d_rem_n = d_qb ? 64'(d_r2 - {1'b0, pr0[63:0]}) : d_r2[63:0];
    d_q_n   = {dq[31:0], d_qb};
    d_big_n = dbig | dq[32];
    d_res   = div_sat(dneg, d_big_n, d_q_n);
  end

  // Square root step: two radicand bits per cycle
  logic [35:0] s_r4, s_trial;
  logic        s_ge;
  always_comb begin
    s_r4    = {srem[33:0], vsh[63:62]};
    s_trial = {2'b00, sroot, 2'b01};
    s_ge    = (s_r4 >= s_trial);
  end

  // Combinational results for add, sub, conj, equal and the mag squared shift
  logic signed [32:0] e_dr, e_di, add_re, add_im, sub_re, sub_im, neg_ai;
  logic [32:0] e_adr, e_adi;
  logic [ACC_W-1:0] msq_sh;
  sat_t s_add_re, s_add_im, s_sub_re, s_sub_im, s_neg_ai;
  always_comb begin
    add_re = 33'(ar) + 33'(br);
    add_im = 33'(ai) + 33'(bi);
    sub_re = 33'(ar) - 33'(br);
    sub_im = 33'(ai) - 33'(bi);
    neg_ai = -33'(ai);
    s_add_re = sat32(ACC_W'(add_re));
    s_add_im = sat32(ACC_W'(add_im));
    s_sub_re = sat32(ACC_W'(sub_re));
    s_sub_im = sat32(ACC_W'(sub_im));
    s_neg_ai = sat32(ACC_W'(neg_ai));
    e_dr   = sub_re;
    e_di   = sub_im;
    e_adr  = e_dr[32] ? 33'(-e_dr) : 33'(e_dr);
    e_adi  = e_di[32] ? 33'(-e_di) : 33'(e_di);
    msq_sh = ACC_W'(pr0 >>> FRAC_BITS);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (req_valid) state_next = S_START;
      S_START: begin
        case (cmd)
          CMD_MUL, CMD_DIV, CMD_MOD, CMD_MSQ: state_next = S_MUL;
          CMD_POW: state_next = (pcnt == '0) ? S_OUT : S_MUL;
          default: state_next = S_OUT;
        endcase
      end
      S_MUL: state_next = S_ACC;
      S_ACC: state_next = (term == last_term) ? S_POST : S_MUL;
      S_POST: begin
        case (cmd)
          CMD_MOD: state_next = S_SQRT;
          CMD_DIV: state_next = (pr0 == '0) ? S_OUT : S_DIV;
          CMD_POW: state_next = (pcnt == PW'(1)) ? S_OUT : S_MUL;
          default: state_next = S_OUT;
        endcase
      end
      S_DIV:  if (dcnt == DCW'(NW - 1) && dsel) state_next = S_OUT;
      S_SQRT: if (scnt == 5'd31) state_next = S_OUT;
      S_OUT:  if (res_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd <= cmd_t'(req.cmd);
          ar  <= req.a_re;
          ai  <= req.a_im;
          br  <= req.b_re;
          bi  <= req.b_im;
          if (cmd_t'(req.cmd) == CMD_POW) begin
            yr <= ONE;
            yi <= '0;
          end else begin
            yr <= req.b_re;
            yi <= req.b_im;
          end
          if (int'(req.exponent) > MAX_EXP) pcnt <= PW'(MAX_EXP);
          else                              pcnt <= PW'(req.exponent);
          term <= '0;
          ov   <= 1'b0;
          out  <= '0;
        end
      end
      S_START: begin
        case (cmd)
          CMD_ADD: begin
            out.res_re   <= s_add_re.val;
            out.res_im   <= s_add_im.val;
            out.overflow <= s_add_re.ov | s_add_im.ov;
          end
          CMD_SUB: begin
            out.res_re   <= s_sub_re.val;
            out.res_im   <= s_sub_im.val;
            out.overflow <= s_sub_re.ov | s_sub_im.ov;
          end
          CMD_CONJ: begin
            out.res_re   <= ar;
            out.res_im   <= s_neg_ai.val;
            out.overflow <= s_neg_ai.ov;
          end
          CMD_EQ: out.is_equal <= (e_adr < {17'b0, tol}) && (e_adi < {17'b0, tol});
          CMD_POW: out.res_re <= ONE;
          default: ;
        endcase
      end
      S_MUL: prod <= opa * opb;
      S_ACC: begin
        if (!term[0]) begin
          acc <= tval;
        end else begin
          case (term[2:1])
            2'd0:    pr0 <= pair_sum;
            2'd1:    pr1 <= pair_sum;
            default: pr2 <= pair_sum;
          endcase
        end
        term <= (term == last_term) ? 3'd0 : term + 3'd1;
      end
      S_POST: begin
        case (cmd)
          CMD_MUL: begin
            out.res_re   <= m_re.val;
            out.res_im   <= m_im.val;
            out.overflow <= m_re.ov | m_im.ov;
          end
          CMD_POW: begin
            yr   <= m_re.val;
            yi   <= m_im.val;
            ov   <= ov | m_re.ov | m_im.ov;
            pcnt <= pcnt - PW'(1);
            out.res_re   <= m_re.val;
            out.res_im   <= m_im.val;
            out.overflow <= ov | m_re.ov | m_im.ov;
          end
          CMD_MSQ: begin
            if (msq_sh > ACC_W'(64'hFFFFFFFF)) begin
              out.magnitude <= 32'hFFFFFFFF;
              out.overflow  <= 1'b1;
            end else begin
              out.magnitude <= msq_sh[31:0];
            end
          end
          CMD_MOD: begin
            vsh   <= pr0[63:0];
            srem  <= '0;
            sroot <= '0;
            scnt  <= '0;
          end
          CMD_DIV: begin
            out.div_zero <= (pr0 == '0);
            numsh <= {(pr1[ACC_W-1] ? 64'(-pr1) : pr1[63:0]), {FRAC_BITS{1'b0}}};
            dneg  <= pr1[ACC_W-1];
            drem  <= '0;
            dq    <= '0;
            dbig  <= 1'b0;
            dsel  <= 1'b0;
            dcnt  <= '0;
          end
          default: ;
        endcase
      end
      S_DIV: begin
        numsh <= numsh << 1;
        drem  <= d_rem_n;
        dq    <= d_q_n;
        dbig  <= d_big_n;
        if (dcnt == DCW'(NW - 1)) begin
          dcnt <= '0;
          if (!dsel) begin
            out.res_re   <= d_res.val;
            out.overflow <= d_res.ov;
            numsh <= {(pr2[ACC_W-1] ? 64'(-pr2) : pr2[63:0]), {FRAC_BITS{1'b0}}};
            dneg  <= pr2[ACC_W-1];
            drem  <= '0;
            dq    <= '0;
            dbig  <= 1'b0;
            dsel  <= 1'b1;
          end else begin
            out.res_im   <= d_res.val;
            out.overflow <= out.overflow | d_res.ov;
          end
        end else begin
          dcnt <= dcnt + DCW'(1);
        end
      end
      S_SQRT: begin
        vsh  <= vsh << 2;
        scnt <= scnt + 5'd1;
        if (s_ge) begin
          srem  <= s_r4 - s_trial;
          sroot <= {sroot[30:0], 1'b1};
          if (scnt == 5'd31) out.magnitude <= {sroot[30:0], 1'b1};
        end else begin
          srem  <= s_r4;
          sroot <= {sroot[30:0], 1'b0};
          if (scnt == 5'd31) out.magnitude <= {sroot[30:0], 1'b0};
        end
      end
      S_OUT: ;
      default: ;
    endcase
  end

  // Tolerance register
  always_ff @(posedge clk) begin
    if (rst) tol <= TOL_RESET;
    else if (psel && penable && pwrite) tol <= pwdata[15:0];
  end

  assign pready    = 1'b1;
  assign prdata    = (paddr == ADDR_TOL) ? {16'b0, tol} : '0;
  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_OUT);
  assign res       = out;

  // Never take a request while a result is pending
  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && res_valid)) else $error("ready while result pending");

  // Divide by zero carries a zero quotient and no overflow
  a_dz_clean: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.div_zero) |-> (res.res_re == '0 && res.res_im == '0 && !res.overflow))
    else $error("div_zero result not clean");

  // Equality result comes with no magnitude and no overflow
  a_eq_clean: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.is_equal) |-> (res.magnitude == '0 && !res.overflow))
    else $error("is_equal result not clean");

  // An accepted request moves the sequencer into the start state
  a_start: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == S_START)) else $error("request not started");

endmodule
